// ----- rtl/wtm_pkg.sv -----
// Shared types, constants and helper functions of the world transform matrix builder.
// Has no dependencies; every other file in rtl/ uses it.
package wtm_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int CORDIC_STEPS_MAX = 32;

    localparam int TRIG_W = 34;
    localparam int Z_W    = 25;
    localparam int PROD_W = 2 * TRIG_W;
    localparam int RND_W  = 70;

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_INV = TRIG_W'(652032874);
    localparam logic signed [25:0] FULL_TURN    = 26'sd23592960;
    localparam logic signed [25:0] HALF_TURN    = 26'sd11796480;
    localparam logic signed [25:0] QUARTER_TURN = 26'sd5898240;
    localparam logic signed [31:0] ONE_Q16      = 32'sd65536;
    localparam logic signed [31:0] SAT_MAX      = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN      = 32'sh80000000;

    // Integer-degree reduction: bias to non-negative, reciprocal of 360
    localparam logic [16:0] DEG_BIAS  = 17'd33120;
    localparam logic [15:0] DEG_RECIP = 16'd46603;
    localparam logic [9:0]  DEG_TURN  = 10'd360;

    localparam logic [1:0] ROW_LAST = 2'd3;

    typedef struct packed {
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic signed [31:0] angle_x;
        logic signed [31:0] angle_y;
        logic signed [31:0] angle_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } obj_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] elem_col0;
        logic signed [31:0] elem_col1;
        logic signed [31:0] elem_col2;
        logic signed [31:0] elem_col3;
        logic               last_row;
    } mtx_row_t;

    // Scale and translation riding along with the angles
    typedef struct packed {
        logic signed [2:0][31:0] scale;
        logic signed [2:0][31:0] shift;
    } side_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
        logic signed [Z_W-1:0]    z;
        logic                     neg;
    } cordic_lane_t;

    typedef struct packed {
        logic en;
        logic vld;
    } pipe_ctl_t;

    function automatic logic signed [Z_W-1:0] atan_deg(input int unsigned i);
        logic signed [Z_W-1:0] a;
        case (i)
            0:       a = Z_W'(2949120);
            1:       a = Z_W'(1740967);
            2:       a = Z_W'(919879);
            3:       a = Z_W'(466945);
            4:       a = Z_W'(234379);
            5:       a = Z_W'(117304);
            6:       a = Z_W'(58666);
            7:       a = Z_W'(29335);
            8:       a = Z_W'(14668);
            9:       a = Z_W'(7334);
            10:      a = Z_W'(3667);
            11:      a = Z_W'(1833);
            12:      a = Z_W'(917);
            13:      a = Z_W'(458);
            14:      a = Z_W'(229);
            15:      a = Z_W'(115);
            16:      a = Z_W'(57);
            17:      a = Z_W'(29);
            18:      a = Z_W'(14);
            19:      a = Z_W'(7);
            20:      a = Z_W'(4);
            21:      a = Z_W'(2);
            22:      a = Z_W'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

    // Round Q2.30-scaled value: add half, floor shift by 30
    function automatic logic signed [RND_W-1:0] round30(input logic signed [RND_W-1:0] v);
        logic signed [RND_W-1:0] half;
        half = RND_W'(64'sd536870912);
        return (v + half) >>> 30;
    endfunction

endpackage

// ----- rtl/wtm_angle_reduce.sv -----
// Two-stage reduction of three Q16.16 degree angles to [-90, 90] plus a negate flag.
// Depends on wtm_pkg.
module wtm_angle_reduce (
    input  logic                               clk,
    input  logic                               rst_n,
    input  wtm_pkg::pipe_ctl_t                 ctl,
    input  logic signed [2:0][31:0]            angle,
    input  wtm_pkg::side_t                     side,
    output logic                               vld_out,
    output logic signed [2:0][wtm_pkg::Z_W-1:0] z_out,
    output logic [2:0]                         neg_out,
    output wtm_pkg::side_t                     side_out
);

    logic              a_vld_reg;
    logic [2:0][16:0]  a_u_reg;
    logic [2:0][8:0]   a_q_reg;
    logic [2:0][15:0]  a_frac_reg;
    wtm_pkg::side_t    a_side_reg;

    logic [2:0][16:0]  a_u_next;
    logic [2:0][8:0]   a_q_next;

    logic              b_vld_reg;
    logic signed [2:0][wtm_pkg::Z_W-1:0] b_z_reg, b_z_next;
    logic [2:0]        b_neg_reg, b_neg_next;
    wtm_pkg::side_t    b_side_reg;

    always_comb
    begin
        logic signed [17:0] us;
        logic [32:0]        prod;
        for (int l = 0; l < 3; l++)
        begin
            us = 18'(signed'(angle[l][31:16])) + signed'({1'b0, wtm_pkg::DEG_BIAS});
            a_u_next[l] = us[16:0];
            prod = 33'(a_u_next[l]) * 33'(wtm_pkg::DEG_RECIP);
            a_q_next[l] = prod[32:24];
        end
    end

    always_comb
    begin
        logic [17:0]        qm;
        logic [17:0]        r;
        logic [9:0]         rd;
        logic signed [25:0] z;
        for (int l = 0; l < 3; l++)
        begin
            qm = 18'(a_q_reg[l]) * 18'(wtm_pkg::DEG_TURN);
            r  = 18'(a_u_reg[l]) - qm;
            rd = r[9:0];
            if (rd >= wtm_pkg::DEG_TURN)
            begin
                rd = rd - wtm_pkg::DEG_TURN;
            end
            z = signed'({1'b0, rd[8:0], a_frac_reg[l]});
            if (z > wtm_pkg::HALF_TURN)
            begin
                z = z - wtm_pkg::FULL_TURN;
            end
            b_neg_next[l] = 1'b0;
            if (z > wtm_pkg::QUARTER_TURN)
            begin
                z = z - wtm_pkg::HALF_TURN;
                b_neg_next[l] = 1'b1;
            end
            else if (z < -wtm_pkg::QUARTER_TURN)
            begin
                z = z + wtm_pkg::HALF_TURN;
                b_neg_next[l] = 1'b1;
            end
            b_z_next[l] = z[wtm_pkg::Z_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            a_vld_reg <= ctl.vld;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            a_u_reg    <= a_u_next;
            a_q_reg    <= a_q_next;
            for (int l = 0; l < 3; l++)
            begin
                a_frac_reg[l] <= angle[l][15:0];
            end
            a_side_reg <= side;
            b_z_reg    <= b_z_next;
            b_neg_reg  <= b_neg_next;
            b_side_reg <= a_side_reg;
        end
    end

    assign vld_out  = b_vld_reg;
    assign z_out    = b_z_reg;
    assign neg_out  = b_neg_reg;
    assign side_out = b_side_reg;

endmodule

// ----- rtl/wtm_cordic.sv -----
// Unrolled rotation-mode CORDIC, one register stage per iteration, three lanes.
// Depends on wtm_pkg.
module wtm_cordic #(
    parameter int STEPS = wtm_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wtm_pkg::pipe_ctl_t                  ctl,
    input  logic signed [2:0][wtm_pkg::Z_W-1:0] z_in,
    input  logic [2:0]                          neg_in,
    input  wtm_pkg::side_t                      side,
    output logic                                vld_out,
    output wtm_pkg::cordic_lane_t [2:0]         lane_out,
    output wtm_pkg::side_t                      side_out
);

    wtm_pkg::cordic_lane_t [2:0] st_in;
    wtm_pkg::cordic_lane_t [2:0] st_reg  [1:STEPS];
    logic                        vld_reg [1:STEPS];
    wtm_pkg::side_t              sd_reg  [1:STEPS];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            st_in[l].x   = wtm_pkg::CORDIC_GAIN_INV;
            st_in[l].y   = '0;
            st_in[l].z   = z_in[l];
            st_in[l].neg = neg_in[l];
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        wtm_pkg::cordic_lane_t [2:0] cur;
        logic                        cur_vld;
        wtm_pkg::side_t              cur_sd;
        wtm_pkg::cordic_lane_t [2:0] step_next;

        if (i == 0)
        begin : g_src
            assign cur     = st_in;
            assign cur_vld = ctl.vld;
            assign cur_sd  = side;
        end
        else
        begin : g_src
            assign cur     = st_reg[i];
            assign cur_vld = vld_reg[i];
            assign cur_sd  = sd_reg[i];
        end

        always_comb
        begin
            logic signed [wtm_pkg::TRIG_W-1:0] xs, ys;
            logic signed [wtm_pkg::Z_W-1:0]    at;
            at = wtm_pkg::atan_deg(i);
            for (int l = 0; l < 3; l++)
            begin
                xs = cur[l].x >>> i;
                ys = cur[l].y >>> i;
                step_next[l].neg = cur[l].neg;
                if (cur[l].z >= 0)
                begin
                    step_next[l].x = cur[l].x - ys;
                    step_next[l].y = cur[l].y + xs;
                    step_next[l].z = cur[l].z - at;
                end
                else
                begin
                    step_next[l].x = cur[l].x + ys;
                    step_next[l].y = cur[l].y - xs;
                    step_next[l].z = cur[l].z + at;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (ctl.en)
            begin
                vld_reg[i+1] <= cur_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                st_reg[i+1] <= step_next;
                sd_reg[i+1] <= cur_sd;
            end
        end
    end

    assign vld_out  = vld_reg[STEPS];
    assign lane_out = st_reg[STEPS];
    assign side_out = sd_reg[STEPS];

endmodule

// ----- rtl/wtm_matrix.sv -----
// Rotation product Rz*Ry*Rx and column scaling, multiply and round in alternate stages.
// Depends on wtm_pkg; fed by wtm_cordic.
module wtm_matrix (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wtm_pkg::pipe_ctl_t           ctl,
    input  wtm_pkg::cordic_lane_t [2:0]  lane,
    input  wtm_pkg::side_t               side,
    output logic                         vld_out,
    output logic signed [2:0][2:0][65:0] prod_out,
    output logic signed [2:0][31:0]      shift_out
);

    localparam int TW = wtm_pkg::TRIG_W;
    localparam int PW = wtm_pkg::PROD_W;
    localparam int RW = wtm_pkg::RND_W;

    logic signed [2:0][TW-1:0] sn, cs;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            sn[l] = lane[l].neg ? -lane[l].y : lane[l].y;
            cs[l] = lane[l].neg ? -lane[l].x : lane[l].x;
        end
    end

    // P1: Ry*Rx products
    logic                      p1_vld_reg;
    logic signed [PW-1:0]      p1_a_reg, p1_b_reg, p1_c_reg, p1_d_reg;
    logic signed [TW-1:0]      p1_cy_reg, p1_sy_reg, p1_cx_reg, p1_nsx_reg;
    logic signed [TW-1:0]      p1_cz_reg, p1_sz_reg;
    wtm_pkg::side_t            p1_side_reg;

    // R1: Ry*Rx rounded
    logic                      r1_vld_reg;
    logic signed [2:0][2:0][TW-1:0] r1_m_reg, r1_m_next;
    logic signed [TW-1:0]      r1_cz_reg, r1_sz_reg;
    wtm_pkg::side_t            r1_side_reg;

    // P2: Rz*(Ry*Rx) products
    logic                      p2_vld_reg;
    logic signed [2:0][PW-1:0] p2_a_reg, p2_b_reg, p2_c_reg, p2_d_reg;
    logic signed [2:0][PW-1:0] p2_a_next, p2_b_next, p2_c_next, p2_d_next;
    logic signed [2:0][TW-1:0] p2_r2_reg;
    wtm_pkg::side_t            p2_side_reg;

    // R2: rotation rounded
    logic                      r2_vld_reg;
    logic signed [2:0][2:0][TW-1:0] r2_rot_reg, r2_rot_next;
    wtm_pkg::side_t            r2_side_reg;

    // P3: scaled products
    logic                      p3_vld_reg;
    logic signed [2:0][2:0][65:0] p3_q_reg, p3_q_next;
    logic signed [2:0][31:0]   p3_shift_reg;

    always_comb
    begin
        logic signed [TW-1:0] z0;
        z0 = '0;
        r1_m_next[0][0] = p1_cy_reg;
        r1_m_next[0][1] = TW'(wtm_pkg::round30(RW'(p1_a_reg)));
        r1_m_next[0][2] = TW'(wtm_pkg::round30(RW'(p1_b_reg)));
        r1_m_next[1][0] = z0;
        r1_m_next[1][1] = p1_cx_reg;
        r1_m_next[1][2] = p1_nsx_reg;
        r1_m_next[2][0] = p1_sy_reg;
        r1_m_next[2][1] = TW'(wtm_pkg::round30(RW'(p1_c_reg)));
        r1_m_next[2][2] = TW'(wtm_pkg::round30(RW'(p1_d_reg)));
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            p2_a_next[j] = r1_cz_reg * signed'(r1_m_reg[0][j]);
            p2_b_next[j] = r1_sz_reg * signed'(r1_m_reg[1][j]);
            p2_c_next[j] = r1_sz_reg * signed'(r1_m_reg[0][j]);
            p2_d_next[j] = r1_cz_reg * signed'(r1_m_reg[1][j]);
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            r2_rot_next[0][j] = TW'(wtm_pkg::round30(RW'(signed'(p2_a_reg[j]))
                                                    - RW'(signed'(p2_b_reg[j]))));
            r2_rot_next[1][j] = TW'(wtm_pkg::round30(RW'(signed'(p2_c_reg[j]))
                                                    + RW'(signed'(p2_d_reg[j]))));
            r2_rot_next[2][j] = p2_r2_reg[j];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p3_q_next[k][j] = signed'(r2_rot_reg[k][j]) * signed'(r2_side_reg.scale[j]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            r1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            r2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            p1_vld_reg <= ctl.vld;
            r1_vld_reg <= p1_vld_reg;
            p2_vld_reg <= r1_vld_reg;
            r2_vld_reg <= p2_vld_reg;
            p3_vld_reg <= r2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            p1_a_reg    <= (-signed'(sn[1])) * signed'(sn[0]);
            p1_b_reg    <= (-signed'(sn[1])) * signed'(cs[0]);
            p1_c_reg    <= signed'(cs[1]) * signed'(sn[0]);
            p1_d_reg    <= signed'(cs[1]) * signed'(cs[0]);
            p1_cy_reg   <= cs[1];
            p1_sy_reg   <= sn[1];
            p1_cx_reg   <= cs[0];
            p1_nsx_reg  <= -signed'(sn[0]);
            p1_cz_reg   <= cs[2];
            p1_sz_reg   <= sn[2];
            p1_side_reg <= side;

            r1_m_reg    <= r1_m_next;
            r1_cz_reg   <= p1_cz_reg;
            r1_sz_reg   <= p1_sz_reg;
            r1_side_reg <= p1_side_reg;

            p2_a_reg    <= p2_a_next;
            p2_b_reg    <= p2_b_next;
            p2_c_reg    <= p2_c_next;
            p2_d_reg    <= p2_d_next;
            p2_r2_reg   <= r1_m_reg[2];
            p2_side_reg <= r1_side_reg;

            r2_rot_reg  <= r2_rot_next;
            r2_side_reg <= p2_side_reg;

            p3_q_reg     <= p3_q_next;
            p3_shift_reg <= r2_side_reg.shift;
        end
    end

    assign vld_out   = p3_vld_reg;
    assign prod_out  = p3_q_reg;
    assign shift_out = p3_shift_reg;

endmodule

// ----- rtl/wtm_row_out.sv -----
// Final rounding and saturation, one-matrix buffer and four-row output sequencer.
// Depends on wtm_pkg; drives the pipeline advance enable.
module wtm_row_out (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         vld_in,
    input  logic signed [2:0][2:0][65:0] prod,
    input  logic signed [2:0][31:0]      shift,
    output logic                         adv,
    output logic                         mtx_valid,
    input  logic                         mtx_stall,
    output wtm_pkg::mtx_row_t            mtx
);

    localparam int RW = wtm_pkg::RND_W;

    logic                          buf_valid_reg, buf_valid_next;
    logic [1:0]                    row_reg, row_next;
    logic signed [2:0][2:0][31:0]  elem_reg, elem_next;
    logic signed [2:0][31:0]       shift_reg;
    logic                          xfer;
    logic                          load;

    assign xfer = buf_valid_reg && !mtx_stall;
    assign adv  = !buf_valid_reg || (xfer && row_reg == wtm_pkg::ROW_LAST);
    assign load = adv && vld_in;

    always_comb
    begin
        logic signed [RW-1:0] r;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r = wtm_pkg::round30(RW'(signed'(prod[k][j])));
                if (r > RW'(wtm_pkg::SAT_MAX))
                begin
                    elem_next[k][j] = wtm_pkg::SAT_MAX;
                end
                else if (r < RW'(wtm_pkg::SAT_MIN))
                begin
                    elem_next[k][j] = wtm_pkg::SAT_MIN;
                end
                else
                begin
                    elem_next[k][j] = r[31:0];
                end
            end
        end
    end

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        row_next       = row_reg;
        if (adv)
        begin
            buf_valid_next = vld_in;
            row_next       = '0;
        end
        else if (xfer)
        begin
            row_next = row_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            row_reg       <= '0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
            row_reg       <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            elem_reg  <= elem_next;
            shift_reg <= shift;
        end
    end

    always_comb
    begin
        mtx.row_index = row_reg;
        mtx.last_row  = (row_reg == wtm_pkg::ROW_LAST);
        case (row_reg)
            2'd0:
            begin
                mtx.elem_col0 = elem_reg[0][0];
                mtx.elem_col1 = elem_reg[0][1];
                mtx.elem_col2 = elem_reg[0][2];
                mtx.elem_col3 = shift_reg[0];
            end
            2'd1:
            begin
                mtx.elem_col0 = elem_reg[1][0];
                mtx.elem_col1 = elem_reg[1][1];
                mtx.elem_col2 = elem_reg[1][2];
                mtx.elem_col3 = shift_reg[1];
            end
            2'd2:
            begin
                mtx.elem_col0 = elem_reg[2][0];
                mtx.elem_col1 = elem_reg[2][1];
                mtx.elem_col2 = elem_reg[2][2];
                mtx.elem_col3 = shift_reg[2];
            end
            default:
            begin
                mtx.elem_col0 = '0;
                mtx.elem_col1 = '0;
                mtx.elem_col2 = '0;
                mtx.elem_col3 = wtm_pkg::ONE_Q16;
            end
        endcase
    end

    assign mtx_valid = buf_valid_reg;

    a_idle_row0: assert property (@(posedge clk) disable iff (!rst_n)
        !buf_valid_reg |-> row_reg == 2'd0)
        else $error("row counter nonzero with empty buffer");

    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && row_reg != wtm_pkg::ROW_LAST) |=>
            (buf_valid_reg && row_reg == $past(row_reg) + 2'd1))
        else $error("row sequence broken");

    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (buf_valid_reg && mtx_stall) |=> (buf_valid_reg && $stable(row_reg)))
        else $error("row changed under stall");

endmodule

// ----- rtl/world_transform_matrix_builder.sv -----
// Top level of the world transform matrix builder.
// Depends on wtm_pkg, wtm_angle_reduce, wtm_cordic, wtm_matrix and wtm_row_out.
//
// Each object transfer (scale, Euler angles in degrees, translation, all Q16.16)
// yields four row transfers of the model matrix T*Rz*Ry*Rx*S, row 0 first, last_row
// set on row 3. The path is fully pipelined: 2 angle-reduction stages, CORDIC_STEPS
// CORDIC stages, 5 multiply/round stages and the output buffer. The four-row output
// sequencer limits the sustained rate to one object per four row transfers;
// obj_stall holds the whole pipeline while the buffered matrix is still being sent.
module world_transform_matrix_builder #(
    parameter int CORDIC_STEPS = wtm_pkg::CORDIC_STEPS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              obj_valid,
    output logic              obj_stall,
    input  wtm_pkg::obj_t     obj,
    output logic              mtx_valid,
    input  logic              mtx_stall,
    output wtm_pkg::mtx_row_t mtx
);

    logic                                adv;
    wtm_pkg::pipe_ctl_t                  ctl_in, ctl_cor, ctl_mat;
    wtm_pkg::side_t                      side_in, side_red, side_cor;
    logic signed [2:0][31:0]             angle;
    logic                                red_vld, cor_vld, mat_vld;
    logic signed [2:0][wtm_pkg::Z_W-1:0] red_z;
    logic [2:0]                          red_neg;
    wtm_pkg::cordic_lane_t [2:0]         cor_lane;
    logic signed [2:0][2:0][65:0]        mat_prod;
    logic signed [2:0][31:0]             mat_shift;

    assign side_in.scale = {obj.scale_z, obj.scale_y, obj.scale_x};
    assign side_in.shift = {obj.shift_z, obj.shift_y, obj.shift_x};
    assign angle         = {obj.angle_z, obj.angle_y, obj.angle_x};

    assign ctl_in  = '{en: adv, vld: obj_valid};
    assign ctl_cor = '{en: adv, vld: red_vld};
    assign ctl_mat = '{en: adv, vld: cor_vld};
    assign obj_stall = !adv;

    wtm_angle_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_in),
        .angle    (angle),
        .side     (side_in),
        .vld_out  (red_vld),
        .z_out    (red_z),
        .neg_out  (red_neg),
        .side_out (side_red)
    );

    wtm_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_cor),
        .z_in     (red_z),
        .neg_in   (red_neg),
        .side     (side_red),
        .vld_out  (cor_vld),
        .lane_out (cor_lane),
        .side_out (side_cor)
    );

    wtm_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_mat),
        .lane      (cor_lane),
        .side      (side_cor),
        .vld_out   (mat_vld),
        .prod_out  (mat_prod),
        .shift_out (mat_shift)
    );

    wtm_row_out u_row_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .vld_in    (mat_vld),
        .prod      (mat_prod),
        .shift     (mat_shift),
        .adv       (adv),
        .mtx_valid (mtx_valid),
        .mtx_stall (mtx_stall),
        .mtx       (mtx)
    );

endmodule
